/* hdl/srsg_pkg.sv */
package srsg_pkg;

	localparam int PITCHES_PER_REV = 16;
	localparam int POSITION_BITS   = 12;
	localparam int REV_W           = 8 + $clog2(PITCHES_PER_REV + 1);
	localparam int CMP_W           = (REV_W > POSITION_BITS + 1) ? REV_W : POSITION_BITS + 1;

	localparam logic [2:0] REQ_TICK     = 3'd0;
	localparam logic [2:0] REQ_RELATIVE = 3'd1;
	localparam logic [2:0] REQ_ABSOLUTE = 3'd2;
	localparam logic [2:0] REQ_ABORT    = 3'd3;
	localparam logic [2:0] REQ_SHUTDOWN = 3'd4;
	localparam logic [2:0] REQ_ZERO     = 3'd5;

	localparam logic [1:0] REG_BASE_PERIOD = 2'd0;
	localparam logic [1:0] REG_RAMP_STEPS  = 2'd1;
	localparam logic [1:0] REG_EXTRA_ABS   = 2'd2;
	localparam logic [1:0] REG_PITCH       = 2'd3;

	localparam logic [7:0] RST_BASE_PERIOD = 8'd4;
	localparam logic [5:0] RST_RAMP_STEPS  = 6'd20;
	localparam logic [3:0] RST_EXTRA_ABS   = 4'd2;
	localparam logic [7:0] RST_PITCH       = 8'd255;

	localparam logic [3:0] CW_TABLE [8] = '{4'h5, 4'h1, 4'h9, 4'h8, 4'hA, 4'h2, 4'h6, 4'h4};
	localparam logic [3:0] CCW_TABLE [8] = '{4'h4, 4'h6, 4'h2, 4'hA, 4'h8, 4'h9, 4'h1, 4'h5};

	typedef struct packed {
		logic [2:0]               req_type;
		logic signed [15:0]       move_distance;
		logic [POSITION_BITS-1:0] target_position;
		logic                     take_long_way;
	} cmd_t;

	typedef struct packed {
		logic [3:0]               coil_drive;
		logic                     moving;
		logic                     step_issued;
		logic                     move_finished;
		logic [POSITION_BITS-1:0] current_position;
	} rsp_t;

	typedef struct packed {
		logic [7:0] step_base_period;
		logic [5:0] ramp_steps;
		logic [3:0] extra_abs_steps;
		logic [7:0] pitch_counts;
	} cfg_t;

	function automatic logic [3:0] step_pattern(input logic cw, input logic [2:0] idx);
		step_pattern = cw ? CW_TABLE[idx] : CCW_TABLE[idx];
	endfunction

endpackage

/* hdl/srsg_regs.sv */
module srsg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output srsg_pkg::cfg_t    cfg
);

	srsg_pkg::cfg_t cfg_q;
	logic           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_base_period <= srsg_pkg::RST_BASE_PERIOD;
			cfg_q.ramp_steps       <= srsg_pkg::RST_RAMP_STEPS;
			cfg_q.extra_abs_steps  <= srsg_pkg::RST_EXTRA_ABS;
			cfg_q.pitch_counts     <= srsg_pkg::RST_PITCH;
		end else if (wr_en) begin
			case (paddr[3:2])
				srsg_pkg::REG_BASE_PERIOD: cfg_q.step_base_period <= pwdata[7:0];
				srsg_pkg::REG_RAMP_STEPS:  cfg_q.ramp_steps       <= pwdata[5:0];
				srsg_pkg::REG_EXTRA_ABS:   cfg_q.extra_abs_steps  <= pwdata[3:0];
				srsg_pkg::REG_PITCH:       cfg_q.pitch_counts     <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			srsg_pkg::REG_BASE_PERIOD: prdata = {24'd0, cfg_q.step_base_period};
			srsg_pkg::REG_RAMP_STEPS:  prdata = {26'd0, cfg_q.ramp_steps};
			srsg_pkg::REG_EXTRA_ABS:   prdata = {28'd0, cfg_q.extra_abs_steps};
			srsg_pkg::REG_PITCH:       prdata = {24'd0, cfg_q.pitch_counts};
			default:                   prdata = 32'd0;
		endcase
	end

endmodule

/* hdl/srsg_core.sv */
module srsg_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  srsg_pkg::cmd_t cmd,
	input  srsg_pkg::cfg_t cfg,
	output srsg_pkg::rsp_t rsp
);

	localparam int PW = srsg_pkg::POSITION_BITS;
	localparam int CW = srsg_pkg::CMP_W;

	logic [7:0]    tick_q, tick_d;
	logic [2:0]    phase_q, phase_d;
	logic          run_q, run_d;
	logic          cw_q, cw_d;
	logic          abs_q, abs_d;
	logic [15:0]   done_q, done_d;
	logic [15:0]   total_q, total_d;
	logic [7:0]    level_q, level_d;
	logic [PW-1:0] pos_q, pos_d;
	logic [3:0]    coil_q, coil_d;
	logic          stepped, finished;

	logic [CW-1:0]      rev;
	logic signed [9:0]  interval;
	logic [7:0]         ival;
	logic [7:0]         tick_inc;
	logic [15:0]        done_inc;
	logic signed [PW:0] diff;
	logic [PW-1:0]      mag;
	logic [CW-1:0]      path;
	logic [16:0]        abs_total;
	logic [15:0]        rel_total;
	logic [16:0]        start_total;
	logic               start_cw;
	logic               start;

	assign rev = CW'(cfg.pitch_counts * srsg_pkg::PITCHES_PER_REV);

	always_comb begin
		interval = $signed({2'b00, cfg.step_base_period}) + $signed({4'b0000, cfg.ramp_steps})
			- $signed({2'b00, level_q});
		if (interval < 10'sd1)
			ival = 8'd1;
		else if (interval > 10'sd255)
			ival = 8'd255;
		else
			ival = interval[7:0];
		tick_inc = tick_q + 8'd1;
		done_inc = done_q + 16'd1;

		diff = $signed({1'b0, cmd.target_position}) - $signed({1'b0, pos_q});
		mag  = diff[PW] ? PW'(-diff) : diff[PW-1:0];
		if (!cmd.take_long_way)
			path = CW'(mag);
		else if (rev > CW'(mag))
			path = rev - CW'(mag);
		else
			path = '0;
		abs_total = 17'(path) + {13'd0, cfg.extra_abs_steps};
		rel_total = cmd.move_distance[15] ? 16'(-cmd.move_distance) : cmd.move_distance;
	end

	always_comb begin
		tick_d   = tick_q;
		phase_d  = phase_q;
		run_d    = run_q;
		cw_d     = cw_q;
		abs_d    = abs_q;
		done_d   = done_q;
		total_d  = total_q;
		level_d  = level_q;
		pos_d    = pos_q;
		coil_d   = coil_q;
		stepped  = 1'b0;
		finished = 1'b0;
		start       = 1'b0;
		start_total = '0;
		start_cw    = 1'b0;

		case (cmd.req_type)
			srsg_pkg::REQ_TICK: begin
				if (run_q) begin
					tick_d = tick_inc;
					if (tick_inc >= ival) begin
						tick_d  = 8'd0;
						coil_d  = srsg_pkg::step_pattern(cw_q, phase_q);
						phase_d = phase_q + 3'd1;
						done_d  = done_inc;
						stepped = 1'b1;
						if (abs_q && done_inc > {12'd0, cfg.extra_abs_steps}) begin
							if (cw_q)
								pos_d = (CW'(pos_q) + CW'(1) >= rev) ? '0 : pos_q + PW'(1);
							else
								pos_d = (pos_q == '0) ? PW'(rev - CW'(1)) : pos_q - PW'(1);
						end
						if (done_inc == total_q) begin
							run_d    = 1'b0;
							finished = 1'b1;
						end
						if (done_inc <= {10'd0, cfg.ramp_steps}) begin
							if (level_q != 8'hFF)
								level_d = level_q + 8'd1;
						end else if (total_q >= done_inc &&
							(total_q - done_inc) <= {10'd0, cfg.ramp_steps}) begin
							if (level_q != 8'd0)
								level_d = level_q - 8'd1;
						end
					end
				end
			end
			srsg_pkg::REQ_RELATIVE: begin
				abs_d       = 1'b0;
				start       = 1'b1;
				start_total = {1'b0, rel_total};
				start_cw    = ~cmd.move_distance[15];
			end
			srsg_pkg::REQ_ABSOLUTE: begin
				abs_d = 1'b1;
				if (diff == '0) begin
					run_d    = 1'b0;
					finished = 1'b1;
				end else begin
					start       = 1'b1;
					start_total = abs_total;
					start_cw    = ~diff[PW] ^ cmd.take_long_way;
				end
			end
			srsg_pkg::REQ_ABORT: begin
				run_d   = 1'b0;
				phase_d = 3'd0;
				tick_d  = 8'd0;
			end
			srsg_pkg::REQ_SHUTDOWN: begin
				run_d   = 1'b0;
				phase_d = 3'd0;
				tick_d  = 8'd0;
				coil_d  = 4'd0;
			end
			srsg_pkg::REQ_ZERO: begin
				pos_d = '0;
			end
			default: ;
		endcase

		if (start) begin
			if (start_total == '0) begin
				run_d    = 1'b0;
				finished = 1'b1;
			end else begin
				total_d = start_total[15:0];
				cw_d    = start_cw;
				done_d  = 16'd0;
				level_d = 8'd0;
				phase_d = 3'd0;
				tick_d  = 8'd0;
				run_d   = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= '0;
			phase_q <= '0;
			run_q   <= 1'b0;
			cw_q    <= 1'b0;
			abs_q   <= 1'b0;
			done_q  <= '0;
			total_q <= '0;
			level_q <= '0;
			pos_q   <= '0;
			coil_q  <= '0;
		end else if (en) begin
			tick_q  <= tick_d;
			phase_q <= phase_d;
			run_q   <= run_d;
			cw_q    <= cw_d;
			abs_q   <= abs_d;
			done_q  <= done_d;
			total_q <= total_d;
			level_q <= level_d;
			pos_q   <= pos_d;
			coil_q  <= coil_d;
		end
	end

	assign rsp.coil_drive       = coil_d;
	assign rsp.moving           = run_d;
	assign rsp.step_issued      = stepped;
	assign rsp.move_finished    = finished;
	assign rsp.current_position = pos_d;

endmodule

/* hdl/stepper_ramp_step_generator_unit.sv */
// Stepper move generator, half-step drive with trapezoidal ramp.
// cmd channel (valid/ready): one tick or command per transfer; each transfer
// yields exactly one transfer on the rsp channel with coil pattern, moving,
// step and finish flags and the tracked position, in order.
// A cmd accepted into the cmd register has its result registered into the
// rsp register, which drives rsp_valid. Throughput: one cmd per clock while
// rsp_ready is high; the move state updates together with the rsp register.
// When rsp_ready is low, the rsp register holds its transfer and one more cmd
// is taken into the input stage; cmd_ready then drops until the rsp register
// drains.
// Configuration through the APB port: base period at 0x0, ramp steps at 0x4,
// extra absolute steps at 0x8, pitch counts at 0xC; write only while idle.
// Reset (arst_n low) stops any move, clears position, coils and pipeline,
// and loads the register defaults 4, 20, 2 and 255.
module stepper_ramp_step_generator_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  srsg_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output srsg_pkg::rsp_t rsp,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [3:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);

	srsg_pkg::cfg_t cfg;
	srsg_pkg::cmd_t cmd_s1;
	logic           vld_s1;
	srsg_pkg::rsp_t rsp_nxt;
	srsg_pkg::rsp_t rsp_s2;
	logic           vld_s2;
	logic           adv;

	assign adv       = vld_s1 & (~vld_s2 | rsp_ready);
	assign cmd_ready = ~vld_s1 | adv;
	assign rsp_valid = vld_s2;
	assign rsp       = rsp_s2;

	srsg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	srsg_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.cmd    (cmd_s1),
		.cfg    (cfg),
		.rsp    (rsp_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (cmd_ready)
				vld_s1 <= cmd_valid;
			if (adv)
				vld_s2 <= 1'b1;
			else if (rsp_ready)
				vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid & cmd_ready)
			cmd_s1 <= cmd;
		if (adv)
			rsp_s2 <= rsp_nxt;
	end

endmodule

/* hdl/srsg_checker.sv */
module srsg_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input srsg_pkg::rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("rsp transfer changed while stalled");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> rsp_valid && !rsp_ready)
		else $error("cmd_ready low without a stalled rsp");

	a_step_coils: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.step_issued |-> rsp.coil_drive != 4'd0)
		else $error("step issued with coils off");

	a_finish_stops: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.move_finished |-> !rsp.moving)
		else $error("move finished while still moving");

endmodule

bind stepper_ramp_step_generator_unit srsg_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_ready (cmd_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

/* tb/sv/tb_stepper_ramp_step_generator_unit.sv */
`timescale 1ns / 1ps

module tb_stepper_ramp_step_generator_unit;

	logic           clk;
	logic           arst_n;
	logic           cmd_valid;
	logic           cmd_ready;
	srsg_pkg::cmd_t cmd;
	logic           rsp_valid;
	logic           rsp_ready;
	srsg_pkg::rsp_t rsp;
	logic           psel;
	logic           penable;
	logic           pwrite;
	logic [3:0]     paddr;
	logic [31:0]    pwdata;
	logic [31:0]    prdata;
	logic           pready;

	stepper_ramp_step_generator_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// configuration as the drive sees it
	logic [7:0] cfg_base  = srsg_pkg::RST_BASE_PERIOD;
	logic [5:0] cfg_ramp  = srsg_pkg::RST_RAMP_STEPS;
	logic [3:0] cfg_extra = srsg_pkg::RST_EXTRA_ABS;
	logic [7:0] cfg_pitch = srsg_pkg::RST_PITCH;

	// predicted move state
	logic [7:0]  drv_tick     = '0;
	logic [2:0]  drv_phase    = '0;
	logic        drv_run      = 1'b0;
	logic        drv_cw       = 1'b0;
	logic        drv_abs      = 1'b0;
	logic [15:0] drv_done     = '0;
	logic [15:0] drv_total    = '0;
	logic [7:0]  drv_ramp_lvl = '0;
	logic [11:0] drv_pos      = '0;
	logic [3:0]  drv_coil     = '0;

	srsg_pkg::rsp_t pending_drive[$];
	srsg_pkg::rsp_t want;
	int   mismatches    = 0;
	int   results_seen  = 0;
	int   steps_seen    = 0;
	int   moves_done    = 0;
	int   items_sent    = 0;
	int   burst_left    = 0;

	function automatic bit start_move(int total, bit cw);
		if (total == 0) begin
			drv_run = 1'b0;
			return 1'b1;
		end
		drv_total    = 16'(total);
		drv_cw       = cw;
		drv_done     = '0;
		drv_ramp_lvl = '0;
		drv_phase    = '0;
		drv_tick     = '0;
		drv_run      = 1'b1;
		return 1'b0;
	endfunction

	function automatic srsg_pkg::rsp_t next_drive(srsg_pkg::cmd_t c);
		srsg_pkg::rsp_t r;
		int   interval;
		int   rev;
		int   diff;
		int   mag;
		int   mv_dist;
		bit   cw;
		bit   stepped;
		bit   finished;
		stepped  = 1'b0;
		finished = 1'b0;
		rev      = int'(cfg_pitch) * srsg_pkg::PITCHES_PER_REV;
		case (c.req_type)
			srsg_pkg::REQ_TICK: begin
				if (drv_run) begin
					interval = int'(cfg_base) + int'(cfg_ramp) - int'(drv_ramp_lvl);
					if (interval < 1) interval = 1;
					if (interval > 255) interval = 255;
					drv_tick = drv_tick + 8'd1;
					if (int'(drv_tick) >= interval) begin
						drv_tick  = '0;
						drv_coil  = drv_cw ? srsg_pkg::CW_TABLE[drv_phase]
							: srsg_pkg::CCW_TABLE[drv_phase];
						drv_phase = drv_phase + 3'd1;
						drv_done  = drv_done + 16'd1;
						stepped   = 1'b1;
						if (drv_abs && drv_done > 16'(cfg_extra)) begin
							if (drv_cw) begin
								if (int'(drv_pos) + 1 >= rev) drv_pos = '0;
								else drv_pos = drv_pos + 12'd1;
							end else if (drv_pos == '0) begin
								drv_pos = 12'(rev - 1);
							end else begin
								drv_pos = drv_pos - 12'd1;
							end
						end
						if (drv_done == drv_total) begin
							drv_run  = 1'b0;
							finished = 1'b1;
						end
						if (int'(drv_done) <= int'(cfg_ramp)) begin
							if (drv_ramp_lvl != 8'hFF) drv_ramp_lvl = drv_ramp_lvl + 8'd1;
						end else if (drv_total >= drv_done &&
								int'(drv_total - drv_done) <= int'(cfg_ramp)) begin
							if (drv_ramp_lvl != 8'd0) drv_ramp_lvl = drv_ramp_lvl - 8'd1;
						end
					end
				end
			end
			srsg_pkg::REQ_RELATIVE: begin
				drv_abs = 1'b0;
				mv_dist = c.move_distance;
				if (mv_dist < 0) finished = start_move(-mv_dist, 1'b0);
				else finished = start_move(mv_dist, 1'b1);
			end
			srsg_pkg::REQ_ABSOLUTE: begin
				drv_abs = 1'b1;
				diff = int'(c.target_position) - int'(drv_pos);
				if (diff == 0) begin
					drv_run  = 1'b0;
					finished = 1'b1;
				end else begin
					mag = diff < 0 ? -diff : diff;
					cw  = diff > 0;
					if (c.take_long_way) begin
						mag = rev > mag ? rev - mag : 0;
						cw  = !cw;
					end
					finished = start_move(mag + int'(cfg_extra), cw);
				end
			end
			srsg_pkg::REQ_ABORT: begin
				drv_run   = 1'b0;
				drv_phase = '0;
				drv_tick  = '0;
			end
			srsg_pkg::REQ_SHUTDOWN: begin
				drv_run   = 1'b0;
				drv_phase = '0;
				drv_tick  = '0;
				drv_coil  = '0;
			end
			srsg_pkg::REQ_ZERO: drv_pos = '0;
			default: ;
		endcase
		r.coil_drive       = drv_coil;
		r.moving           = drv_run;
		r.step_issued      = stepped;
		r.move_finished    = finished;
		r.current_position = drv_pos;
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// receiver stalls: rsp_ready follows one of four patterns, re-picked at random
	initial begin
		int mode;
		int cyc;
		mode = 0;
		cyc  = 0;
		rsp_ready = 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 100 == 0) mode = $urandom_range(0, 3);
			case (mode)
				0: rsp_ready <= 1'b1;
				1: rsp_ready <= ($urandom_range(0, 9) < 7);
				2: rsp_ready <= (cyc % 5 < 2);
				default: rsp_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// checks each rsp transfer, then predicts each accepted cmd transfer
	always @(posedge clk) begin
		if (rsp_valid && rsp_ready) begin
			results_seen++;
			steps_seen += rsp.step_issued;
			moves_done += rsp.move_finished;
			if (pending_drive.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected rsp coil=%h mov=%b step=%b fin=%b pos=%0d",
						$realtime, rsp.coil_drive, rsp.moving, rsp.step_issued,
						rsp.move_finished, rsp.current_position);
			end else begin
				want = pending_drive.pop_front();
				if (rsp !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: exp coil=%h mov=%b step=%b fin=%b pos=%0d,",
							$realtime, want.coil_drive, want.moving, want.step_issued,
							want.move_finished, want.current_position,
							" got coil=%h mov=%b step=%b fin=%b pos=%0d",
							rsp.coil_drive, rsp.moving, rsp.step_issued,
							rsp.move_finished, rsp.current_position);
				end
			end
		end
		if (cmd_valid && cmd_ready)
			pending_drive.push_back(next_drive(cmd));
	end

	task automatic send_cmd(logic [2:0] req, int mv_dist, int target, bit longway);
		srsg_pkg::cmd_t c;
		int   gap;
		c.req_type        = req;
		c.move_distance   = 16'(mv_dist);
		c.target_position = 12'(target);
		c.take_long_way   = longway;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		burst_left--;
		cmd_valid <= 1'b1;
		cmd       <= c;
		do @(posedge clk); while (!cmd_ready);
		items_sent++;
	endtask

	task automatic send_tick();
		send_cmd(srsg_pkg::REQ_TICK, $urandom_range(0, 65534) - 32767,
			$urandom_range(0, 4095), 1'($urandom_range(0, 1)));
	endtask

	task automatic wait_idle();
		int guard;
		guard = 0;
		cmd_valid <= 1'b0;
		while (pending_drive.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			srsg_pkg::REG_BASE_PERIOD: cfg_base  = val[7:0];
			srsg_pkg::REG_RAMP_STEPS:  cfg_ramp  = val[5:0];
			srsg_pkg::REG_EXTRA_ABS:   cfg_extra = val[3:0];
			srsg_pkg::REG_PITCH:       cfg_pitch = val[7:0];
			default: ;
		endcase
	endtask

	task automatic set_config(int base, int ramp, int extra, int pitch);
		wait_idle();
		write_reg(srsg_pkg::REG_BASE_PERIOD, base);
		write_reg(srsg_pkg::REG_RAMP_STEPS, ramp);
		write_reg(srsg_pkg::REG_EXTRA_ABS, extra);
		write_reg(srsg_pkg::REG_PITCH, pitch);
	endtask

	task automatic run_random(int n, int max_dist, int max_ticks);
		int start;
		int sel;
		int len;
		int mv_dist;
		int rev;
		start = items_sent;
		while (items_sent - start < n) begin
			sel = $urandom_range(0, 99);
			rev = int'(cfg_pitch) * srsg_pkg::PITCHES_PER_REV;
			if (sel < 12) begin
				sel = $urandom_range(0, 9);
				if (sel == 0) mv_dist = 0;
				else if (sel == 1) mv_dist = $urandom_range(0, 65534) - 32767;
				else mv_dist = $urandom_range(1, max_dist);
				if (sel > 1 && $urandom_range(0, 1)) mv_dist = -mv_dist;
				send_cmd(srsg_pkg::REQ_RELATIVE, mv_dist, $urandom_range(0, 4095),
					1'($urandom_range(0, 1)));
			end else if (sel < 22) begin
				send_cmd(srsg_pkg::REQ_ABSOLUTE, $urandom_range(0, 65534) - 32767,
					($urandom_range(0, 9) < 7) ? $urandom_range(0, rev - 1)
						: $urandom_range(0, 4095),
					1'($urandom_range(0, 1)));
			end else if (sel < 25) begin
				send_cmd(srsg_pkg::REQ_ABORT, $urandom_range(0, 65534) - 32767,
					$urandom_range(0, 4095), 1'($urandom_range(0, 1)));
			end else if (sel < 28) begin
				send_cmd(srsg_pkg::REQ_SHUTDOWN, $urandom_range(0, 65534) - 32767,
					$urandom_range(0, 4095), 1'($urandom_range(0, 1)));
			end else if (sel < 31) begin
				send_cmd(srsg_pkg::REQ_ZERO, $urandom_range(0, 65534) - 32767,
					$urandom_range(0, 4095), 1'($urandom_range(0, 1)));
			end else begin
				len = $urandom_range(1, max_ticks);
				repeat (len) send_tick();
			end
		end
	endtask

	task automatic test_directed_cases();
		send_tick();
		send_cmd(3'd6, 0, 0, 1'b0);
		set_config(1, 2, 0, 1);
		send_cmd(srsg_pkg::REQ_RELATIVE, 0, 0, 1'b0);
		send_cmd(srsg_pkg::REQ_RELATIVE, 3, 0, 1'b0);
		repeat (6) send_tick();
		send_cmd(srsg_pkg::REQ_RELATIVE, -32767, 4095, 1'b1);
		repeat (2) send_tick();
		send_cmd(srsg_pkg::REQ_ABORT, 0, 0, 1'b0);
		send_cmd(srsg_pkg::REQ_RELATIVE, 32767, 0, 1'b0);
		send_cmd(srsg_pkg::REQ_SHUTDOWN, 0, 0, 1'b0);
		send_cmd(srsg_pkg::REQ_ABSOLUTE, 0, 5, 1'b0);
		send_cmd(srsg_pkg::REQ_ZERO, 0, 0, 1'b0);
		// long way from 0 to 1: counter-clockwise, wraps to the top
		send_cmd(srsg_pkg::REQ_ABSOLUTE, 0, 1, 1'b1);
		repeat (3) send_tick();
		// long way shorter than zero clamps to a zero-length move
		send_cmd(srsg_pkg::REQ_ABSOLUTE, 0, 4095, 1'b1);
		send_cmd(srsg_pkg::REQ_ABSOLUTE, 0, 20, 1'b0);
		repeat (3) send_tick();
		send_cmd(srsg_pkg::REQ_ABSOLUTE, 0, 0, 1'b0);
		send_cmd(3'd7, -1, 4095, 1'b1);
	endtask

	task automatic test_fast_ramp();
		set_config(1, 0, 0, 1);
		run_random(450, 40, 40);
	endtask

	task automatic test_random_settings();
		repeat (2) begin
			set_config($urandom_range(1, 6), $urandom_range(0, 10), $urandom_range(0, 15),
				$urandom_range(1, 8));
			run_random(250, 30, 60);
		end
	endtask

	task automatic test_slow_ramp();
		set_config(255, 63, 15, 255);
		run_random(300, 3, 300);
	endtask

	task automatic test_default_settings();
		set_config(srsg_pkg::RST_BASE_PERIOD, srsg_pkg::RST_RAMP_STEPS,
			srsg_pkg::RST_EXTRA_ABS, srsg_pkg::RST_PITCH);
		run_random(450, 8, 80);
	endtask

	initial begin
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd       = '0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_fast_ramp();
		test_random_settings();
		test_slow_ramp();
		test_default_settings();

		wait_idle();
		repeat (8) @(posedge clk);
		if (pending_drive.size() != 0) begin
			mismatches++;
			$display("%0d responses never arrived", pending_drive.size());
		end
		$display("Sent %0d commands and ticks over several register settings", items_sent);
		$display("Checked %0d responses: %0d steps, %0d finished moves, %0d mismatches",
			results_seen, steps_seen, moves_done, mismatches);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* sim.f */
hdl/srsg_pkg.sv
hdl/srsg_regs.sv
hdl/srsg_core.sv
hdl/stepper_ramp_step_generator_unit.sv
hdl/srsg_checker.sv
tb/sv/tb_stepper_ramp_step_generator_unit.sv
